>>> src/fttg_pkg.sv
`timescale 1ns / 1ps

package fttg_pkg;

   localparam int SINE_DEPTH = 1024;
   localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
   localparam int MAX_BLOCK_SAMPLES = 4096;
   localparam int OFFSET_W = 12;
   localparam int SIZE_W = 13;

   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic [1:0] {
      STATUS_SAMPLE     = 2'd0,
      STATUS_CANCELLED  = 2'd1,
      STATUS_DISCONNECT = 2'd2,
      STATUS_OVERRUN    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      REG_SAMPLES_PER_BLOCK = 4'd0,
      REG_BLOCK_DURATION    = 4'd1,
      REG_PHASE_STEP        = 4'd2,
      REG_AMPLITUDE         = 4'd3,
      REG_TONE_ENABLE       = 4'd4,
      REG_DISCONNECT_LIMIT  = 4'd5,
      REG_XRUN_PERIOD       = 4'd6,
      REG_START_TIME        = 4'd7
   } csr_index_type;

   typedef struct packed {
      status_type           status;
      logic signed [15:0]   sample_value;
      logic [31:0]          block_number;
      logic [62:0]          block_time_us;
      logic [OFFSET_W-1:0]  sample_offset;
      logic                 block_last;
   } rsp_type;

   // Q1.15 sine entry k (17 bits, full scale 32768 fits), quarter-wave Taylor in Q30
   function automatic logic signed [16:0] sine_entry(input int k);
      int          u;
      int          quad;
      int          r;
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] mag;
      u = 4 * k;
      quad = u / SINE_DEPTH;
      r = u % SINE_DEPTH;
      if ((quad & 1) != 0) begin
         t = (64'(SINE_DEPTH - r) << 30) / SINE_DEPTH;
      end else begin
         t = (64'(r) << 30) / SINE_DEPTH;
      end
      x = (t * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      acc = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         term = ((x2 * acc) >> 30) / TAYLOR_DIV[i];
         acc = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      end
      acc = (x * acc) >> 30;
      if (acc > Q30_ONE) begin
         acc = Q30_ONE;
      end
      mag = (acc * 64'd32768 + 64'd536870912) >> 30;
      if (mag > 64'd32768) begin
         mag = 64'd32768;
      end
      return ((quad & 2) != 0) ? -signed'(mag[16:0]) : signed'(mag[16:0]);
   endfunction

endpackage

>>> src/framed_test_tone_generator_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_cancel
// rsp     | out       | rsp_valid/rsp_stall | status, sample, block, time, offset, last
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One request per cycle while req_stall is low; each result is registered in the output queue before it appears on rsp.
// A two-entry output queue keeps requests flowing while one result is stalled.
// A write of xrun_period runs a 32-step remainder of the block number;
// requests wait until the new remainder has landed, further writes wait while it runs.
// Reset is synchronous; the queue empties and the configuration and block state return to defaults.

module framed_test_tone_generator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cancel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_sample_value,
   output logic [31:0]        rsp_block_number,
   output logic [62:0]        rsp_block_time_us,
   output logic [11:0]        rsp_sample_offset,
   output logic               rsp_block_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int OW = fttg_pkg::OFFSET_W;
   localparam int SW = fttg_pkg::SIZE_W;

   // configuration
   logic [SW-1:0] spb_ff;
   logic [19:0]   dur_ff;
   logic [31:0]   step_ff;
   logic [15:0]   amp_ff;
   logic          en_ff;
   logic [31:0]   limit_ff;
   logic [15:0]   period_ff;

   // block state
   logic [OW-1:0] offset_ff, offset_in;
   logic [31:0]   block_ff, block_in;
   logic [31:0]   phase_ff, phase_in;
   logic [62:0]   time_ff, time_in;
   logic [31:0]   ob_ff, ob_in;
   logic          seen_ff, seen_in;
   logic [15:0]   rem_ff, rem_in;

   // output queue
   fttg_pkg::rsp_type fifo_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;

   logic              cfg_wr;
   logic              div_start, div_busy, div_done;
   logic [15:0]       div_rem;
   logic              push, pop;
   logic              at_start, disc, xrun, last;
   logic [SW-1:0]     eff_size;
   logic [16:0]       rem_inc;
   logic signed [15:0] tone;
   fttg_pkg::status_type status;
   fttg_pkg::rsp_type  result;
   fttg_pkg::rsp_type  head;

   assign cfg_wr = csr_valid && csr_ready;
   assign csr_ready = !div_busy;
   assign div_start = cfg_wr && (fttg_pkg::csr_index_type'(csr_index) == fttg_pkg::REG_XRUN_PERIOD);

   fttg_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (block_ff),
      .divisor   (csr_data[15:0]),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   fttg_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .phase_in  (phase_in),
      .amplitude (amp_ff),
      .enable    (en_ff),
      .sample    (tone)
   );

   // hold requests until the new remainder has landed in rem_ff
   assign req_stall = (count_ff == 2'd2) || div_busy || div_start || div_done;
   assign push = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      priority if (spb_ff == '0) begin
         eff_size = SW'(1);
      end else if (spb_ff > SW'(fttg_pkg::MAX_BLOCK_SAMPLES)) begin
         eff_size = SW'(fttg_pkg::MAX_BLOCK_SAMPLES);
      end else begin
         eff_size = spb_ff;
      end
   end

   assign at_start = (offset_ff == '0);
   assign disc = (limit_ff != '1) && (block_ff >= limit_ff);
   assign xrun = (period_ff != '0) && (block_ff != '0) && (rem_ff == '0)
                 && !(seen_ff && (ob_ff == block_ff));
   assign last = ({1'b0, offset_ff} + SW'(1)) >= eff_size;
   assign rem_inc = {1'b0, rem_ff} + 17'd1;

   always_comb begin
      priority if (!at_start) begin
         status = fttg_pkg::STATUS_SAMPLE;
      end else if (req_cancel) begin
         status = fttg_pkg::STATUS_CANCELLED;
      end else if (disc) begin
         status = fttg_pkg::STATUS_DISCONNECT;
      end else if (xrun) begin
         status = fttg_pkg::STATUS_OVERRUN;
      end else begin
         status = fttg_pkg::STATUS_SAMPLE;
      end
   end

   always_comb begin
      result.status = status;
      result.block_number = block_ff;
      result.block_time_us = time_ff;
      if (status == fttg_pkg::STATUS_SAMPLE) begin
         result.sample_value = tone;
         result.sample_offset = offset_ff;
         result.block_last = last;
      end else begin
         result.sample_value = '0;
         result.sample_offset = '0;
         result.block_last = 1'b0;
      end
   end

   always_comb begin
      offset_in = offset_ff;
      block_in = block_ff;
      phase_in = phase_ff;
      time_in = time_ff;
      ob_in = ob_ff;
      seen_in = seen_ff;
      rem_in = rem_ff;
      if (div_done) begin
         rem_in = div_rem;
      end
      if (push) begin
         if (status == fttg_pkg::STATUS_OVERRUN) begin
            ob_in = block_ff;
            seen_in = 1'b1;
         end
         if (status == fttg_pkg::STATUS_SAMPLE) begin
            phase_in = phase_ff + step_ff;
            if (last) begin
               offset_in = '0;
               block_in = block_ff + 32'd1;
               time_in = time_ff + {43'd0, dur_ff};
               // track block_number mod xrun_period; the wrap to zero restarts it
               if (block_ff == '1 || rem_inc == {1'b0, period_ff}) begin
                  rem_in = '0;
               end else begin
                  rem_in = rem_inc[15:0];
               end
            end else begin
               offset_in = offset_ff + OW'(1);
            end
         end
      end
      if (cfg_wr && fttg_pkg::csr_index_type'(csr_index) == fttg_pkg::REG_START_TIME) begin
         time_in = csr_data[62:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= SW'(480);
         dur_ff <= 20'd10000;
         step_ff <= 32'd42949673;
         amp_ff <= 16'd16384;
         en_ff <= 1'b1;
         limit_ff <= '1;
         period_ff <= '0;
      end else if (cfg_wr) begin
         unique case (fttg_pkg::csr_index_type'(csr_index))
            fttg_pkg::REG_SAMPLES_PER_BLOCK: spb_ff <= csr_data[SW-1:0];
            fttg_pkg::REG_BLOCK_DURATION:    dur_ff <= csr_data[19:0];
            fttg_pkg::REG_PHASE_STEP:        step_ff <= csr_data[31:0];
            fttg_pkg::REG_AMPLITUDE:         amp_ff <= csr_data[15:0];
            fttg_pkg::REG_TONE_ENABLE:       en_ff <= csr_data[0];
            fttg_pkg::REG_DISCONNECT_LIMIT:  limit_ff <= csr_data[31:0];
            fttg_pkg::REG_XRUN_PERIOD:       period_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         block_ff <= '0;
         phase_ff <= '0;
         time_ff <= '0;
         ob_ff <= '0;
         seen_ff <= 1'b0;
         rem_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         offset_ff <= offset_in;
         block_ff <= block_in;
         phase_ff <= phase_in;
         time_ff <= time_in;
         ob_ff <= ob_in;
         seen_ff <= seen_in;
         rem_ff <= rem_in;
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   assign head = fifo_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign rsp_status = head.status;
   assign rsp_sample_value = head.sample_value;
   assign rsp_block_number = head.block_number;
   assign rsp_block_time_us = head.block_time_us;
   assign rsp_sample_offset = head.sample_offset;
   assign rsp_block_last = head.block_last;

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("output queue overflow");
   a_overrun_once: assert property (@(posedge clock) disable iff (reset)
      (push && status == fttg_pkg::STATUS_OVERRUN) |=>
         (seen_ff && ob_ff == $past(block_ff) && $stable(block_ff) && offset_ff == '0))
      else $error("overrun did not record its block");
   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      (push && status == fttg_pkg::STATUS_SAMPLE && !last) |=>
         (offset_ff == $past(offset_ff) + OW'(1)))
      else $error("offset did not advance");
   a_block_step: assert property (@(posedge clock) disable iff (reset)
      (push && status == fttg_pkg::STATUS_SAMPLE && last) |=>
         (offset_ff == '0 && block_ff == $past(block_ff) + 32'd1))
      else $error("block did not advance at its end");
`endif

endmodule

>>> src/fttg_tone.sv
`timescale 1ns / 1ps

module fttg_tone (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        phase_in,
   input  logic [15:0]        amplitude,
   input  logic               enable,
   output logic signed [15:0] sample
);

   logic signed [16:0] rom [fttg_pkg::SINE_DEPTH];

   for (genvar k = 0; k < fttg_pkg::SINE_DEPTH; k++) begin : g_rom
      localparam logic signed [16:0] ENTRY = fttg_pkg::sine_entry(k);
      assign rom[k] = ENTRY;
   end

   logic [fttg_pkg::SINE_ADDR_W-1:0] idx;
   logic signed [16:0]               entry_ff;
   logic signed [33:0]               prod;
   logic [32:0]                      mag;
   logic [47:0]                      scaled;
   logic [15:0]                      level;

   // look up the entry for the phase the accumulator takes at this edge
   assign idx = phase_in[31 -: fttg_pkg::SINE_ADDR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         // phase zero reads a zero entry
         entry_ff <= '0;
      end else begin
         entry_ff <= rom[idx];
      end
   end

   assign prod = $signed({18'd0, amplitude}) * 34'(entry_ff);
   assign mag = prod[33] ? 33'(-prod) : prod[32:0];

   // scale |P| by 32767 as a shift and subtract, round half away from zero
   assign scaled = ({15'd0, mag} << 15) - {15'd0, mag} + 48'd536870912;

   always_comb begin
      if (mag >= 33'd1073741824) begin
         level = 16'd32767;
      end else begin
         level = scaled[45:30];
      end
   end

   always_comb begin
      if (!enable) begin
         sample = '0;
      end else if (prod[33]) begin
         sample = -$signed(level);
      end else begin
         sample = $signed(level);
      end
   end

endmodule

>>> src/fttg_rem_div.sv
`timescale 1ns / 1ps

module fttg_rem_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [15:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [16:0] trial;

   // one restoring step per cycle while busy, dividend bits taken msb first
   assign trial = {rem_ff[15:0], quot_ff[31]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '1;
         quot_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         quot_in = quot_ff << 1;
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign remainder = rem_ff[15:0];

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("remainder unit restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff) else $error("busy dropped without done");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
`endif

endmodule

>>> tb/framed_test_tone_generator_top_test.sv
`timescale 1ns / 1ps

module framed_test_tone_generator_top_test;

   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD = 300;
   localparam int MAX_PRINTED = 40;
   localparam logic [3:0] UNUSED_CSR_INDEX = 4'd11;
   localparam bit [63:0] ONE_Q30 = 64'd1073741824;
   localparam bit [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
   localparam bit [63:0] TAYLOR_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
   localparam bit [21:0] OPENING_CANCELS = 22'b1010000000000000000100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cancel = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_sample_value;
   logic [31:0]        rsp_block_number;
   logic [62:0]        rsp_block_time_us;
   logic [11:0]        rsp_sample_offset;
   logic               rsp_block_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;

   framed_test_tone_generator_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cancel        (req_cancel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_block_number  (rsp_block_number),
      .rsp_block_time_us (rsp_block_time_us),
      .rsp_sample_offset (rsp_sample_offset),
      .rsp_block_last    (rsp_block_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // generator registers as the testbench tracks them
   bit [12:0] cfg_block_size = 13'd480;
   bit [19:0] cfg_duration = 20'd10000;
   bit [31:0] cfg_phase_step = 32'd42949673;
   bit [15:0] cfg_amplitude = 16'd16384;
   bit        cfg_tone_on = 1'b1;
   bit [31:0] cfg_disc_limit = 32'hFFFF_FFFF;
   bit [15:0] cfg_xrun_period = 16'd0;
   bit [62:0] cfg_start_time = '0;

   // generator position
   bit [11:0] slot_offset = '0;
   bit [31:0] blk_num = '0;
   bit [31:0] phase = '0;
   bit [62:0] blk_time = '0;
   bit [31:0] xrun_blk = '0;
   bit        xrun_seen = 1'b0;

   int                sine_tbl [fttg_pkg::SINE_DEPTH];
   fttg_pkg::rsp_type tone_expected [$];
   bit                pending_cancels [$];

   bit        req_taken = 1'b0;
   int        idle_odds = 4;
   int        send_gap = 0;
   int        stall_left = 0;
   bit        hold_pending = 1'b0;
   int        quiet_cycles = 0;
   int        mismatches = 0;
   int        results_checked = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int sine_q15(input int k);
      int        quarter;
      int        rem;
      bit [63:0] frac;
      bit [63:0] arg;
      bit [63:0] arg_sq;
      bit [63:0] poly;
      bit [63:0] term;
      bit [63:0] mag;
      quarter = (4 * k) / fttg_pkg::SINE_DEPTH;
      rem = (4 * k) % fttg_pkg::SINE_DEPTH;
      if (quarter % 2 == 1) begin
         frac = (64'(fttg_pkg::SINE_DEPTH - rem) << 30) / 64'(fttg_pkg::SINE_DEPTH);
      end else begin
         frac = (64'(rem) << 30) / 64'(fttg_pkg::SINE_DEPTH);
      end
      arg = (frac * QUARTER_TURN_Q30) >> 30;
      arg_sq = (arg * arg) >> 30;
      poly = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
         term = ((arg_sq * poly) >> 30) / TAYLOR_DIVS[i];
         poly = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
      end
      poly = (arg * poly) >> 30;
      if (poly > ONE_Q30) begin
         poly = ONE_Q30;
      end
      mag = (poly * 64'd32768 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32768) begin
         mag = 64'd32768;
      end
      return (quarter >= 2) ? -int'(mag) : int'(mag);
   endfunction

   function automatic int block_len();
      int n;
      n = cfg_block_size;
      if (n == 0) begin
         n = 1;
      end
      if (n > fttg_pkg::MAX_BLOCK_SAMPLES) begin
         n = fttg_pkg::MAX_BLOCK_SAMPLES;
      end
      if (n > (1 << fttg_pkg::OFFSET_W)) begin
         n = 1 << fttg_pkg::OFFSET_W;
      end
      return n;
   endfunction

   // scale the table entry by the gain, clamp to +-1 and round half away from zero
   function automatic logic signed [15:0] tone_value();
      int              idx;
      longint          prod;
      longint unsigned m;
      int              v;
      idx = int'((64'(phase) * fttg_pkg::SINE_DEPTH) >> 32);
      prod = longint'(cfg_amplitude) * longint'(sine_tbl[idx]);
      m = (prod < 0) ? -prod : prod;
      if (m >= ONE_Q30) begin
         v = 32767;
      end else begin
         v = int'((m * 64'd32767 + (64'd1 << 29)) >> 30);
      end
      return (prod < 0) ? 16'(-v) : 16'(v);
   endfunction

   function automatic void predict_slot(input bit cancel);
      fttg_pkg::rsp_type want;
      want = '0;
      want.status = fttg_pkg::STATUS_SAMPLE;
      if (slot_offset == 0) begin
         if (cancel) begin
            want.status = fttg_pkg::STATUS_CANCELLED;
         end else if (cfg_disc_limit != 32'hFFFF_FFFF && blk_num >= cfg_disc_limit) begin
            want.status = fttg_pkg::STATUS_DISCONNECT;
         end else if (cfg_xrun_period != 0 && blk_num != 0 &&
                      blk_num % cfg_xrun_period == 0 &&
                      !(xrun_seen && xrun_blk == blk_num)) begin
            xrun_blk = blk_num;
            xrun_seen = 1'b1;
            want.status = fttg_pkg::STATUS_OVERRUN;
         end
      end
      want.block_number = blk_num;
      want.block_time_us = blk_time;
      if (want.status == fttg_pkg::STATUS_SAMPLE) begin
         want.sample_offset = slot_offset;
         want.sample_value = cfg_tone_on ? tone_value() : 16'sd0;
         want.block_last = (int'(slot_offset) + 1 >= block_len());
         phase = phase + cfg_phase_step;
         if (want.block_last) begin
            slot_offset = '0;
            blk_num = blk_num + 1;
            blk_time = blk_time + cfg_duration;
         end else begin
            slot_offset = slot_offset + 1;
         end
      end
      tone_expected.push_back(want);
   endfunction

   function automatic void apply_config(input logic [3:0] idx, input logic [63:0] value);
      case (idx)
         fttg_pkg::REG_SAMPLES_PER_BLOCK: cfg_block_size = value[12:0];
         fttg_pkg::REG_BLOCK_DURATION:    cfg_duration = value[19:0];
         fttg_pkg::REG_PHASE_STEP:        cfg_phase_step = value[31:0];
         fttg_pkg::REG_AMPLITUDE:         cfg_amplitude = value[15:0];
         fttg_pkg::REG_TONE_ENABLE:       cfg_tone_on = value[0];
         fttg_pkg::REG_DISCONNECT_LIMIT:  cfg_disc_limit = value[31:0];
         fttg_pkg::REG_XRUN_PERIOD:       cfg_xrun_period = value[15:0];
         fttg_pkg::REG_START_TIME: begin
            cfg_start_time = value[62:0];
            blk_time = value[62:0];
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < MAX_PRINTED) begin
         $display("mismatch in %s on result %0d: got %h, want %h",
                  field, results_checked, got, want);
      end
      mismatches++;
   endtask

   // request side: hold until taken, insert random gaps
   always @(negedge clock) begin
      logic next_valid;
      logic next_cancel;
      next_valid = req_valid;
      next_cancel = req_cancel;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            send_gap = $urandom_range(0, 17);
         end else if (pending_cancels.size() != 0) begin
            next_valid = 1'b1;
            next_cancel = pending_cancels.pop_front();
         end
      end
      req_valid <= next_valid;
      req_cancel <= next_cancel;
   end

   // result side: random stall bursts, plus one long hold on request
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      fttg_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (tone_expected.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_status), 64'd0);
            end else begin
               want = tone_expected.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               end
               if (rsp_sample_value !== want.sample_value) begin
                  report_mismatch("sample_value", 64'(rsp_sample_value),
                                  64'(want.sample_value));
               end
               if (rsp_block_number !== want.block_number) begin
                  report_mismatch("block_number", 64'(rsp_block_number),
                                  64'(want.block_number));
               end
               if (rsp_block_time_us !== want.block_time_us) begin
                  report_mismatch("block_time_us", 64'(rsp_block_time_us),
                                  64'(want.block_time_us));
               end
               if (rsp_sample_offset !== want.sample_offset) begin
                  report_mismatch("sample_offset", 64'(rsp_sample_offset),
                                  64'(want.sample_offset));
               end
               if (rsp_block_last !== want.block_last) begin
                  report_mismatch("block_last", 64'(rsp_block_last), 64'(want.block_last));
               end
            end
            results_checked++;
         end
         if (req_valid && !req_stall) begin
            predict_slot(req_cancel);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

   task automatic write_csr(input logic [3:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_config(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every request to be taken and answered, then let the block settle
   task automatic settle();
      do @(posedge clock);
      while (pending_cancels.size() != 0 || req_valid || tone_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_slots(input int count, input int cancel_odds);
      for (int i = 0; i < count; i++) begin
         pending_cancels.push_back($urandom_range(1, cancel_odds) == 1);
      end
   endtask

   task automatic shuffle_config();
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 9))
            0:       write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, {$urandom, $urandom});
            1, 2:    write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'($urandom_range(13, 200)));
            default: write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'($urandom_range(0, 12)));
         endcase
      end
      if ($urandom_range(0, 1) == 1) begin
         write_csr(fttg_pkg::REG_BLOCK_DURATION, {$urandom, $urandom});
      end
      if ($urandom_range(0, 1) == 1) begin
         write_csr(fttg_pkg::REG_PHASE_STEP, {$urandom, $urandom});
      end
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 4))
            0:       write_csr(fttg_pkg::REG_AMPLITUDE, 64'd0);
            1:       write_csr(fttg_pkg::REG_AMPLITUDE, 64'hFFFF);
            2:       write_csr(fttg_pkg::REG_AMPLITUDE, 64'h8000);
            default: write_csr(fttg_pkg::REG_AMPLITUDE, {$urandom, $urandom});
         endcase
      end
      if ($urandom_range(0, 2) == 0) begin
         write_csr(fttg_pkg::REG_TONE_ENABLE, {$urandom, $urandom});
      end
      if ($urandom_range(0, 1) == 1) begin
         if ($urandom_range(0, 9) < 7) begin
            write_csr(fttg_pkg::REG_DISCONNECT_LIMIT, {$urandom, 32'hFFFF_FFFF});
         end else begin
            write_csr(fttg_pkg::REG_DISCONNECT_LIMIT,
                      {$urandom, blk_num + 32'($urandom_range(0, 6))});
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         if ($urandom_range(0, 5) == 0) begin
            write_csr(fttg_pkg::REG_XRUN_PERIOD, {$urandom, $urandom});
         end else begin
            write_csr(fttg_pkg::REG_XRUN_PERIOD, 64'($urandom_range(0, 5)));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         write_csr(fttg_pkg::REG_START_TIME, {$urandom, $urandom});
      end
      if ($urandom_range(0, 7) == 0) begin
         write_csr(UNUSED_CSR_INDEX, {$urandom, $urandom});
      end
   endtask

   initial begin
      for (int k = 0; k < fttg_pkg::SINE_DEPTH; k++) begin
         sine_tbl[k] = sine_q15(k);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short blocks, overrun on every block after the first, disconnect from block four,
      // timestamp wrapping, full gain on the four quarter-turn peaks
      write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'd3);
      write_csr(fttg_pkg::REG_BLOCK_DURATION, 64'd1000000);
      write_csr(fttg_pkg::REG_PHASE_STEP, 64'h4000_0000);
      write_csr(fttg_pkg::REG_AMPLITUDE, 64'hFFFF);
      write_csr(fttg_pkg::REG_TONE_ENABLE, 64'd1);
      write_csr(fttg_pkg::REG_DISCONNECT_LIMIT, 64'd4);
      write_csr(fttg_pkg::REG_XRUN_PERIOD, 64'd1);
      write_csr(fttg_pkg::REG_START_TIME, 64'h7FFF_FFFF_FFE9_1CA0);
      write_csr(UNUSED_CSR_INDEX, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 21; i >= 0; i--) begin
         pending_cancels.push_back(OPENING_CANCELS[i]);
      end
      settle();

      // zero size acts as one, unity gain, maximum step, timestamp at its top
      write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'd0);
      write_csr(fttg_pkg::REG_AMPLITUDE, 64'h8000);
      write_csr(fttg_pkg::REG_PHASE_STEP, 64'hFFFF_FFFF);
      write_csr(fttg_pkg::REG_DISCONNECT_LIMIT, 64'hFFFF_FFFF);
      write_csr(fttg_pkg::REG_XRUN_PERIOD, 64'd0);
      write_csr(fttg_pkg::REG_START_TIME, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_slots(60, 6);
      settle();

      // oversized block saturates, silence, frozen phase, sparse overrun
      write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'h1FFF);
      write_csr(fttg_pkg::REG_TONE_ENABLE, 64'd0);
      write_csr(fttg_pkg::REG_AMPLITUDE, 64'd0);
      write_csr(fttg_pkg::REG_PHASE_STEP, 64'd0);
      write_csr(fttg_pkg::REG_XRUN_PERIOD, 64'hFFFF);
      write_csr(fttg_pkg::REG_BLOCK_DURATION, 64'd1);
      queue_slots(150, 4);
      settle();

      // shrink the block while mid-block
      write_csr(fttg_pkg::REG_SAMPLES_PER_BLOCK, 64'd5);
      write_csr(fttg_pkg::REG_TONE_ENABLE, 64'd1);
      write_csr(fttg_pkg::REG_AMPLITUDE, {$urandom, $urandom});
      write_csr(fttg_pkg::REG_PHASE_STEP, {$urandom, $urandom});
      queue_slots(40, 8);
      settle();

      // back up the result side so the block stops taking requests
      shuffle_config();
      idle_odds = 0;
      hold_pending = 1'b1;
      queue_slots(200, 10);
      settle();

      for (int p = 0; p < 12; p++) begin
         shuffle_config();
         case ($urandom_range(0, 3))
            0: idle_odds = 0;
            1: idle_odds = 3;
            2: idle_odds = 5;
            default: idle_odds = 10;
         endcase
         queue_slots(60, ($urandom_range(0, 3) == 0) ? 2 : 10);
         settle();
      end

      // no idling on either side to finish
      shuffle_config();
      idle_odds = 0;
      queue_slots(100, 8);
      settle();

      if (tone_expected.size() != 0) begin
         report_mismatch("results never seen", 64'(tone_expected.size()), 64'd0);
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
